[design/linear_probe_hash_table_top_assert.svh]
// Assertion macros used by the top-level design file.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LPHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LPHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LPHT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPHT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/lpht_pkg.sv]
package lpht_pkg;
    localparam int SLOTS     = 256;
    localparam int IDX_BITS  = $clog2(SLOTS);
    localparam int CNT_BITS  = IDX_BITS + 1;
    localparam int KEY_BITS  = 32;
    localparam int DATA_BITS = 32;

    typedef enum logic [1:0] {
        REQ_SEARCH = 2'd0,
        REQ_UPSERT = 2'd1,
        REQ_ADD    = 2'd2,
        REQ_ERASE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DUPLICATE = 3'd4,
        ST_FULL      = 3'd5,
        ST_BAD_INDEX = 3'd6,
        ST_ERASED    = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DREAD,
        S_DONE
    } t_state;
endpackage

[design/linear_probe_hash_table_top.sv]
// Linear-probing hash table over 256 slots. Each word brings a home slot, key and data;
// the block probes one slot per pass through S_READ and S_CHECK (a registered read of the key
// memory and the slot flags, then the key compare). A search that hits adds a data read in
// S_DREAD before the result word in S_DONE. A probe can run the whole ring of capacity slots,
// as an insert does once it has passed a tombstone, unless it meets its key. It is not ready
// while a request is at work. One result word follows every request.
// Slot flags are cleared at reset at once; there is no clearing pass.
`include "linear_probe_hash_table_top_assert.svh"
module linear_probe_hash_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] req_type, [9:2] home_index, [41:10] key, [73:42] data, [79:74] zero
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [34:3] read_data, [43:35] entry_count, [47:44] zero
    output logic [47:0] m_axis_tdata
);
    import lpht_pkg::*;

    t_state r_state, n_state;
    logic [8:0] r_cap;
    logic [SLOTS-1:0] r_has, r_used;
    logic [CNT_BITS-1:0] r_live;
    t_req r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [DATA_BITS-1:0] r_data;
    logic [IDX_BITS-1:0] r_idx, r_free;
    logic [CNT_BITS-1:0] r_n, r_ring;
    logic r_tomb, r_have_free, r_hit;
    logic r_used_rd, r_has_rd;
    t_status r_status;
    logic [DATA_BITS-1:0] r_rd;

    logic [KEY_BITS-1:0] key_q;
    logic [DATA_BITS-1:0] data_q;
    logic key_we, data_we;
    logic [IDX_BITS-1:0] wr_addr, rd_addr;

    lpht_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(wr_addr), .i_wdata(r_key),
        .i_raddr(rd_addr), .o_rdata(key_q));
    lpht_ram #(.WIDTH(DATA_BITS), .DEPTH(SLOTS)) u_data (
        .i_clk(i_clk), .i_we(data_we), .i_waddr(wr_addr), .i_wdata(r_data),
        .i_raddr(rd_addr), .o_rdata(data_q));

    logic accept;
    logic used_i, has_i, match, last, ins_op;
    logic [IDX_BITS-1:0] idx_nx;
    logic [CNT_BITS-1:0] cap_eff;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign used_i = r_used_rd;
    assign has_i = r_has_rd;
    assign match = has_i && (key_q == r_key);
    assign last = (r_n + CNT_BITS'(1)) >= r_ring;
    assign idx_nx = (CNT_BITS'(r_idx) + CNT_BITS'(1) >= r_ring) ? '0 : r_idx + IDX_BITS'(1);
    assign ins_op = (r_op == REQ_UPSERT) || (r_op == REQ_ADD);
    assign rd_addr = r_idx;
    assign cap_eff = (r_cap == '0) ? CNT_BITS'(1)
                   : (r_cap > 9'(SLOTS)) ? CNT_BITS'(SLOTS) : CNT_BITS'(r_cap);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_READ;
            S_READ:  n_state = S_CHECK;
            S_CHECK: begin
                if (r_hit) n_state = S_DONE;
                else if (r_op == REQ_SEARCH && used_i && match) n_state = S_DREAD;
                else if (!used_i && (!ins_op || !r_tomb)) n_state = S_DONE;
                else if (match || last) n_state = S_DONE;
                else n_state = S_READ;
            end
            S_DREAD: n_state = S_DONE;
            S_DONE:  if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and memory writes.
    always_comb begin
        key_we = 1'b0;
        data_we = 1'b0;
        wr_addr = r_idx;
        s_axis_tready = (r_state == S_IDLE);
        m_axis_tvalid = (r_state == S_DONE);
        if (r_state == S_CHECK && !r_hit && ins_op && used_i && match
            && r_op == REQ_UPSERT) begin
            data_we = 1'b1;
        end
        if (r_state == S_CHECK && !r_hit && ins_op) begin
            if (!(used_i && match) && ((!used_i && !r_tomb) || last)) begin
                if (r_have_free || !has_i) begin
                    key_we = 1'b1;
                    data_we = 1'b1;
                    wr_addr = r_have_free ? r_free : r_idx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap <= 9'(SLOTS);
            r_has <= '0;
            r_used <= '0;
            r_live <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            if (r_state == S_CHECK && !r_hit && key_we) begin
                r_has[wr_addr] <= 1'b1;
                r_used[wr_addr] <= 1'b1;
                r_live <= r_live + CNT_BITS'(1);
            end
            if (r_state == S_CHECK && !r_hit && r_op == REQ_ERASE && used_i && match) begin
                r_has[r_idx] <= 1'b0;
                if (r_live != '0) r_live <= r_live - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op <= t_req'(s_axis_tdata[1:0]);
                r_idx <= s_axis_tdata[9:2];
                r_key <= s_axis_tdata[41:10];
                r_data <= s_axis_tdata[73:42];
                r_ring <= cap_eff;
                r_n <= '0;
                r_tomb <= 1'b0;
                r_have_free <= 1'b0;
                r_free <= '0;
                r_rd <= '0;
                r_status <= ST_NOT_FOUND;
                r_hit <= (CNT_BITS'(s_axis_tdata[9:2]) >= cap_eff);
                if (CNT_BITS'(s_axis_tdata[9:2]) >= cap_eff) r_status <= ST_BAD_INDEX;
            end
            S_READ: begin
                r_used_rd <= r_used[r_idx];
                r_has_rd <= r_has[r_idx];
            end
            S_CHECK: if (!r_hit) begin
                if (ins_op) begin
                    if (used_i && match) begin
                        r_status <= (r_op == REQ_UPSERT) ? ST_UPDATED : ST_DUPLICATE;
                    end else if ((!used_i && !r_tomb) || last) begin
                        r_status <= (r_have_free || !has_i) ? ST_INSERTED : ST_FULL;
                    end else begin
                        if (used_i && !has_i) r_tomb <= 1'b1;
                        if (!r_have_free && !has_i) begin
                            r_have_free <= 1'b1;
                            r_free <= r_idx;
                        end
                    end
                end else if (used_i && match) begin
                    r_status <= (r_op == REQ_SEARCH) ? ST_FOUND : ST_ERASED;
                end
                r_n <= r_n + CNT_BITS'(1);
                r_idx <= idx_nx;
                if (used_i && match && r_op == REQ_SEARCH) r_idx <= r_idx;
            end
            S_DREAD: r_rd <= data_q;
            default: ;
        endcase
    end

    assign m_axis_tdata = {4'd0, r_live, r_rd, r_status};

    `LPHT_ASSERT_IMP(a_one_side, i_clk, i_rst_n, 1'b1, !(s_axis_tready && m_axis_tvalid))
    `LPHT_ASSERT_IMP(a_live_le, i_clk, i_rst_n, 1'b1, r_live <= CNT_BITS'(SLOTS))
    `LPHT_ASSERT_NXT(a_acc, i_clk, i_rst_n, accept, r_state == S_READ)
endmodule

[design/lpht_ram.sv]
module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
